// ===== src/zrf_pkg.sv =====
package zrf_pkg;

	// frame geometry
	localparam int FRAME_WIDTH  = 512;
	localparam int FRAME_HEIGHT = 512;
	localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W       = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

	// field widths
	localparam int COORD_W = 10;
	localparam int PIX_W   = 9;
	localparam int COLOR_W = 8;
	localparam int DEPTH_W = 16;
	localparam int COUNT_W = 19;
	localparam int ENTRY_W = 3 * COLOR_W + DEPTH_W;

	// stream widths, tdata in whole bytes
	localparam int S_TDATA_W = 104;
	localparam int M_TDATA_W = 64;
	localparam int S_TUSER_W = 2;

	localparam logic [DEPTH_W-1:0] DEPTH_FAR = '1;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_DRAW  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef struct packed {
		action_t             action;
		logic [COLOR_W-1:0]  red;
		logic [COLOR_W-1:0]  green;
		logic [COLOR_W-1:0]  blue;
		logic [DEPTH_W-1:0]  rect_depth;
		logic [COORD_W-1:0]  x_min;
		logic [COORD_W-1:0]  x_max;
		logic [COORD_W-1:0]  y_min;
		logic [COORD_W-1:0]  y_max;
		logic [PIX_W-1:0]    pixel_x;
		logic [PIX_W-1:0]    pixel_y;
	} item_t;

	typedef struct packed {
		logic [COLOR_W-1:0]  out_red;
		logic [COLOR_W-1:0]  out_green;
		logic [COLOR_W-1:0]  out_blue;
		logic [DEPTH_W-1:0]  out_depth;
		logic [COUNT_W-1:0]  pixels_written;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic clr_step;
		logic drw_step;
		logic rd_issue;
		logic load_out;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		action_t action;
		logic    empty;
		logic    clr_last;
		logic    drw_last;
	} sts_t;

endpackage

// ===== src/zbuffer_rect_fill.sv =====
// A clear item sweeps every pixel of the frame, a draw item walks the clipped area (an empty
// rectangle skips the walk), and a read item reads one entry, before the result is loaded.
// Throughput: one item at a time; a draw or clear walks the frame store one pixel per
// cycle through its single read and single write port.
// Reset (arst_n low) clears the controller state, the output valid flag and the held
// action and count; the frame store holds undefined contents until the first clear item.
module zbuffer_rect_fill (
	input  logic                           clk,
	input  logic                           arst_n,
	// item input
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// red, green, blue, rect_depth, x_min, x_max, y_min, y_max, pixel_x, pixel_y
	input  logic [zrf_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// action
	input  logic [zrf_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	// result output
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// out_red, out_green, out_blue, out_depth, pixels_written
	output logic [zrf_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
	import zrf_pkg::*;

	item_t   item;
	result_t result;
	cmd_t    cmd;
	sts_t    sts;

	// unpack the incoming item, lowest field first
	always_comb begin
		item.action     = action_t'(s_axis_tuser[1:0]);
		item.red        = s_axis_tdata[7:0];
		item.green      = s_axis_tdata[15:8];
		item.blue       = s_axis_tdata[23:16];
		item.rect_depth = s_axis_tdata[39:24];
		item.x_min      = s_axis_tdata[49:40];
		item.x_max      = s_axis_tdata[59:50];
		item.y_min      = s_axis_tdata[69:60];
		item.y_max      = s_axis_tdata[79:70];
		item.pixel_x    = s_axis_tdata[88:80];
		item.pixel_y    = s_axis_tdata[97:89];
	end

	// sequencer: clear sweep, rectangle walk, single read
	zrf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.s_valid(s_axis_tvalid),
		.s_ready(s_axis_tready),
		.m_valid(m_axis_tvalid),
		.m_ready(m_axis_tready),
		.sts    (sts),
		.cmd    (cmd)
	);

	// frame store, address walk, depth test, result register
	zrf_datapath u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.sts   (sts),
		.result(result)
	);

	// result packed lowest field first, padded to whole bytes
	assign m_axis_tdata = {
		(M_TDATA_W - 3 * COLOR_W - DEPTH_W - COUNT_W)'(0),
		result.pixels_written,
		result.out_depth,
		result.out_blue,
		result.out_green,
		result.out_red
	};

endmodule

// ===== src/zrf_ram.sv =====
module zrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic                                        rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/zrf_datapath.sv =====
module zrf_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  zrf_pkg::item_t   item,
	input  zrf_pkg::cmd_t    cmd,
	output zrf_pkg::sts_t    sts,
	output zrf_pkg::result_t result
);
	import zrf_pkg::*;

	action_t              action_q;
	logic [3*COLOR_W-1:0] color_q;
	logic [DEPTH_W-1:0]   depth_q;
	logic [COORD_W-1:0]   x0_q, x1_q, y1_q, x_q, y_q;
	logic [ADDR_W-1:0]    row_base_q, clr_addr_q, pix_addr_q;
	logic                 pix_in_q, empty_q;
	logic [COUNT_W-1:0]   count_q;
	logic [ADDR_W-1:0]    addr_s1;
	logic                 valid_s1;
	result_t              result_q, result_d;

	logic [COORD_W-1:0]   x1c, y1c;
	logic [ADDR_W-1:0]    drw_addr, rd_addr, wr_addr;
	logic [ENTRY_W-1:0]   wr_data, rd_data;
	logic                 wr_en, rd_en, nearer, x_wrap;

	// clip the exclusive bounds to the frame
	always_comb begin
		x1c = (32'(item.x_max) > FRAME_WIDTH) ? COORD_W'(FRAME_WIDTH) : item.x_max;
		y1c = (32'(item.y_max) > FRAME_HEIGHT) ? COORD_W'(FRAME_HEIGHT) : item.y_max;
	end

	assign drw_addr = row_base_q + ADDR_W'(x_q);
	assign x_wrap   = ((COORD_W + 1)'(x_q) + (COORD_W + 1)'(1)) == (COORD_W + 1)'(x1_q);

	assign sts.action   = action_q;
	assign sts.empty    = empty_q;
	assign sts.clr_last = clr_addr_q == ADDR_W'(FRAME_PIXELS - 1);
	assign sts.drw_last = x_wrap &&
		(((COORD_W + 1)'(y_q) + (COORD_W + 1)'(1)) == (COORD_W + 1)'(y1_q));

	// item fields, held for the whole item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			color_q    <= {item.red, item.green, item.blue};
			depth_q    <= item.rect_depth;
			x0_q       <= item.x_min;
			x1_q       <= x1c;
			y1_q       <= y1c;
			empty_q    <= (item.x_min >= x1c) || (item.y_min >= y1c);
			pix_in_q   <= (32'(item.pixel_x) < FRAME_WIDTH) &&
				(32'(item.pixel_y) < FRAME_HEIGHT);
			pix_addr_q <= ADDR_W'(32'(item.pixel_y) * FRAME_WIDTH + 32'(item.pixel_x));
		end
	end

	// walk counters
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q        <= item.x_min;
			y_q        <= item.y_min;
			row_base_q <= ADDR_W'(32'(item.y_min) * FRAME_WIDTH);
			clr_addr_q <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			if (cmd.drw_step) begin
				if (x_wrap) begin
					x_q        <= x0_q;
					y_q        <= y_q + COORD_W'(1);
					row_base_q <= row_base_q + ADDR_W'(FRAME_WIDTH);
				end else begin
					x_q <= x_q + COORD_W'(1);
				end
			end
		end
		addr_s1 <= drw_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			action_q <= ACT_NONE;
			valid_s1 <= 1'b0;
			count_q  <= '0;
		end else begin
			valid_s1 <= cmd.drw_step;
			if (cmd.capture) begin
				action_q <= item.action;
				count_q  <= '0;
			end else if (wr_en && !cmd.clr_step) begin
				count_q <= count_q + COUNT_W'(1);
			end
		end
	end

	// depth test on the stored entry read in the cycle before
	assign nearer  = depth_q < rd_data[DEPTH_W-1:0];
	assign wr_en   = cmd.clr_step || (valid_s1 && nearer);
	assign wr_addr = cmd.clr_step ? clr_addr_q : addr_s1;
	assign wr_data = cmd.clr_step ? {{(3 * COLOR_W){1'b0}}, DEPTH_FAR} : {color_q, depth_q};
	assign rd_en   = cmd.rd_issue || cmd.drw_step;
	assign rd_addr = cmd.rd_issue ? pix_addr_q : drw_addr;

	zrf_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(FRAME_PIXELS)
	) u_frame_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		result_d = '0;
		case (action_q)
			ACT_CLEAR: result_d.pixels_written = COUNT_W'(FRAME_PIXELS);
			ACT_DRAW:  result_d.pixels_written = count_q;
			ACT_READ: begin
				if (pix_in_q) begin
					result_d.out_red   = rd_data[ENTRY_W-1 -: COLOR_W];
					result_d.out_green = rd_data[ENTRY_W-COLOR_W-1 -: COLOR_W];
					result_d.out_blue  = rd_data[DEPTH_W +: COLOR_W];
					result_d.out_depth = rd_data[DEPTH_W-1:0];
				end
			end
			default: result_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q <= result_d;
		end
	end

	assign result = result_q;

endmodule

// ===== src/zrf_ctrl.sv =====
module zrf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_valid,
	output logic           s_ready,
	output logic           m_valid,
	input  logic           m_ready,
	input  zrf_pkg::sts_t  sts,
	output zrf_pkg::cmd_t  cmd
);
	import zrf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_CLEAR,
		ST_DRAW,
		ST_DRAIN,
		ST_READ,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   m_valid_q;

	assign s_ready = state_q == ST_IDLE;
	assign m_valid = m_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.capture  = s_ready && s_valid;
		cmd.clr_step = state_q == ST_CLEAR;
		cmd.drw_step = state_q == ST_DRAW;
		cmd.rd_issue = state_q == ST_READ;
		cmd.load_out = (state_q == ST_DONE) && (!m_valid_q || m_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_valid) state_q <= ST_START;
				end
				ST_START: begin
					case (sts.action)
						ACT_CLEAR: state_q <= ST_CLEAR;
						ACT_DRAW:  state_q <= sts.empty ? ST_DONE : ST_DRAW;
						ACT_READ:  state_q <= ST_READ;
						default:   state_q <= ST_DONE;
					endcase
				end
				ST_CLEAR: begin
					if (sts.clr_last) state_q <= ST_DONE;
				end
				ST_DRAW: begin
					if (sts.drw_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_DONE;
				ST_READ:  state_q <= ST_DONE;
				ST_DONE: begin
					if (cmd.load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
